// File: hdl/complementary_tilt_filter_defines.svh
// Assertion shorthands for the tilt filter; each assumes clk and arst_n in scope.
`ifndef COMPLEMENTARY_TILT_FILTER_DEFINES_SVH
`define COMPLEMENTARY_TILT_FILTER_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define CTF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define CTF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CTF_ASSERT_SAME(lbl, ante, cons, msg)
`define CTF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hdl/ctf_pkg.sv
package ctf_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int ANGLE_W    = 24;
	localparam int KEEP_W     = 17;
	localparam int MAG_W      = 17;
	localparam int GAIN_W     = 16;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 4;

	localparam int KEEP_ONE      = 65536;
	localparam int KEEP_RST      = 64225;
	localparam int MAG_LOW_RST   = 8192;
	localparam int MAG_HIGH_RST  = 32768;
	localparam int GAIN_RST      = 639;
	localparam int GAIN_FRAC     = 8;
	localparam int KEEP_FRAC     = 16;

	localparam int CORDIC_STEPS_DEF    = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 12;
	localparam int TBL_FRAC            = 20;
	localparam int TBL_LEN             = 24;
	localparam int TBL_IDX_W           = 5;
	localparam int ATAN_W              = 27;
	localparam int CORDIC_PRESCALE     = 8;
	localparam int XY_W                = 27;
	localparam int Z_W                 = 30;
	localparam int QUARTER_TURN        = 94371840;
	localparam int MUL_A_W             = 18;

	localparam int ANGLE_MAX = 2**(ANGLE_W-1) - 1;
	localparam int ANGLE_MIN = -(2**(ANGLE_W-1));

	typedef enum logic [1:0] {
		REG_BLEND_KEEP = 2'd0,
		REG_MAG_LOW    = 2'd1,
		REG_MAG_HIGH   = 2'd2,
		REG_GYRO_GAIN  = 2'd3
	} reg_idx_t;

	// atan(2^-i) in 2^-20 degree units
	function automatic logic [ATAN_W-1:0] atan_entry(input logic [TBL_IDX_W-1:0] idx);
		logic [ATAN_W-1:0] r;
		unique case (idx)
			5'd0:  r = ATAN_W'(47185920);
			5'd1:  r = ATAN_W'(27855475);
			5'd2:  r = ATAN_W'(14718068);
			5'd3:  r = ATAN_W'(7471121);
			5'd4:  r = ATAN_W'(3750058);
			5'd5:  r = ATAN_W'(1876857);
			5'd6:  r = ATAN_W'(938658);
			5'd7:  r = ATAN_W'(469357);
			5'd8:  r = ATAN_W'(234682);
			5'd9:  r = ATAN_W'(117342);
			5'd10: r = ATAN_W'(58671);
			5'd11: r = ATAN_W'(29335);
			5'd12: r = ATAN_W'(14668);
			5'd13: r = ATAN_W'(7334);
			5'd14: r = ATAN_W'(3667);
			5'd15: r = ATAN_W'(1833);
			5'd16: r = ATAN_W'(917);
			5'd17: r = ATAN_W'(458);
			5'd18: r = ATAN_W'(229);
			5'd19: r = ATAN_W'(115);
			5'd20: r = ATAN_W'(57);
			5'd21: r = ATAN_W'(29);
			5'd22: r = ATAN_W'(14);
			5'd23: r = ATAN_W'(7);
			default: r = '0;
		endcase
		return r;
	endfunction

	// |v| with |-32768| = 32768
	function automatic logic [MAG_W-1:0] abs_sample(input logic signed [SAMPLE_W-1:0] v);
		logic signed [SAMPLE_W:0] e;
		e = {v[SAMPLE_W-1], v};
		return v[SAMPLE_W-1] ? MAG_W'(-e) : MAG_W'(e);
	endfunction

endpackage

// File: hdl/ctf_if.sv
interface ctf_in_if import ctf_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] accel_x;
	logic signed [SAMPLE_W-1:0] accel_y;
	logic signed [SAMPLE_W-1:0] accel_z;
	logic signed [SAMPLE_W-1:0] gyro_x;
	logic signed [SAMPLE_W-1:0] gyro_y;

	modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, output ready);
endinterface

interface ctf_out_if import ctf_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [ANGLE_W-1:0] pitch_angle;
	logic signed [ANGLE_W-1:0] roll_angle;
	logic                      corrected;

	modport source (output valid, pitch_angle, roll_angle, corrected, input ready);
	modport sink (input valid, pitch_angle, roll_angle, corrected, output ready);
endinterface

// File: hdl/complementary_tilt_filter.sv
// Pitch/roll complementary filter for a six-axis motion sensor.
// sample: one item per timer tick with raw accel x/y/z and gyro x/y.
// result: one item per tick with saturated pitch and roll (1/4096 degree
//   at the default fraction) and a flag that the accelerometer blend ran.
// APB port: blend_keep at 0x0, mag_low at 0x4, mag_high at 0x8, gyro_gain
//   at 0xC; write only while no item is in flight. pready is tied high.
// One CORDIC vectoring unit, one step per cycle, runs N = min(CORDIC_STEPS, 24)
//   steps of atan2 for pitch then roll, and a single 18-bit by wide multiplier
//   serves gyro scaling and both blends.
// sample.ready is high only while the sequencer is idle; the next item can be
//   taken in the cycle after the result register loads.
// The result register holds one item; while it is stalled the next item is
//   still accepted and computed, and only its final load waits.
// Reset clears pitch and roll to zero and loads the register defaults.
`include "complementary_tilt_filter_defines.svh"

module complementary_tilt_filter import ctf_pkg::*; #(
	parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ctf_in_if.sink                sample,
	ctf_out_if.source             result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int NSTEPS = (CORDIC_STEPS < TBL_LEN) ? CORDIC_STEPS : TBL_LEN;
	localparam int CNT_W  = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;
	localparam int SH     = TBL_FRAC - ANGLE_FRAC_BITS;
	localparam int ACC_W  = Z_W - SH;
	localparam int MB_W   = (ACC_W > ANGLE_W) ? ACC_W : ANGLE_W;
	localparam int P_W    = MUL_A_W + MB_W;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_GX     = 11'b000_0000_0010,
		S_GY     = 11'b000_0000_0100,
		S_GEND   = 11'b000_0000_1000,
		S_CINIT  = 11'b000_0001_0000,
		S_CITER  = 11'b000_0010_0000,
		S_CROUND = 11'b000_0100_0000,
		S_BA     = 11'b000_1000_0000,
		S_BB     = 11'b001_0000_0000,
		S_BC     = 11'b010_0000_0000,
		S_OUT    = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	logic [KEEP_W-1:0] keep_q;
	logic [MAG_W-1:0]  mag_low_q, mag_high_q;
	logic [GAIN_W-1:0] gain_q;

	logic signed [SAMPLE_W-1:0] ax_q, ay_q, az_q, gx_q, gy_q;
	logic                       corr_q, axis_q, zero_q;
	logic [CNT_W-1:0]           cnt_q;
	logic signed [XY_W-1:0]     x_q, y_q;
	logic signed [Z_W-1:0]      z_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [P_W-1:0]      prod_q, sum_q;
	logic signed [ANGLE_W-1:0]  pitch_q, roll_q;

	logic signed [ANGLE_W-1:0] out_pitch_q, out_roll_q;
	logic                      out_corr_q, out_valid_q;

	logic                     cfg_wr;
	reg_idx_t                 cfg_idx;
	logic [MAG_W:0]           mag_sum;
	logic                     corr_d;
	logic [KEEP_W-1:0]        keep_eff, keep_rest;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [P_W-1:0]    prod_d, gyro_step, blend_sum;
	logic signed [ANGLE_W-1:0] angle_sel, blend_ang;
	logic signed [SAMPLE_W-1:0] y_src;
	logic signed [XY_W-1:0]   xs, ys, sx, sy;
	logic signed [Z_W-1:0]    tbl, z_rnd, z_shr;
	logic                     in_acc, out_free;

	function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [P_W-1:0] v);
		logic signed [ANGLE_W-1:0] r;
		if (v > P_W'(ANGLE_MAX)) begin
			r = ANGLE_W'(ANGLE_MAX);
		end else if (v < P_W'(ANGLE_MIN)) begin
			r = ANGLE_W'(ANGLE_MIN);
		end else begin
			r = v[ANGLE_W-1:0];
		end
		return r;
	endfunction

	assign pready       = 1'b1;
	assign cfg_wr       = psel && penable && pwrite && pready;
	assign cfg_idx      = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign sample.ready = (state_q == S_IDLE);
	assign in_acc       = sample.valid && sample.ready;
	assign out_free     = !out_valid_q || result.ready;

	assign result.valid       = out_valid_q;
	assign result.pitch_angle = out_pitch_q;
	assign result.roll_angle  = out_roll_q;
	assign result.corrected   = out_corr_q;

	always_comb begin
		unique case (cfg_idx)
			REG_BLEND_KEEP: prdata = CFG_DATA_W'(keep_q);
			REG_MAG_LOW:    prdata = CFG_DATA_W'(mag_low_q);
			REG_MAG_HIGH:   prdata = CFG_DATA_W'(mag_high_q);
			REG_GYRO_GAIN:  prdata = CFG_DATA_W'(gain_q);
		endcase
	end

	assign mag_sum = (MAG_W+1)'(abs_sample(ax_q)) + (MAG_W+1)'(abs_sample(ay_q))
		+ (MAG_W+1)'(abs_sample(az_q));
	assign corr_d  = (mag_sum > {1'b0, mag_low_q}) && (mag_sum < {1'b0, mag_high_q});

	assign keep_eff  = (keep_q > KEEP_W'(KEEP_ONE)) ? KEEP_W'(KEEP_ONE) : keep_q;
	assign keep_rest = KEEP_W'(KEEP_ONE) - keep_eff;
	assign angle_sel = axis_q ? roll_q : pitch_q;

	// shared multiplier
	always_comb begin
		unique case (state_q)
			S_GX: begin
				mul_a = $signed({2'b00, gain_q});
				mul_b = MB_W'(gx_q);
			end
			S_GY: begin
				mul_a = $signed({2'b00, gain_q});
				mul_b = MB_W'(gy_q);
			end
			S_BA: begin
				mul_a = $signed({1'b0, keep_eff});
				mul_b = MB_W'(angle_sel);
			end
			S_BB: begin
				mul_a = $signed({1'b0, keep_rest});
				mul_b = MB_W'(acc_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d    = mul_a * mul_b;
	assign gyro_step = (prod_q + P_W'(2**(GAIN_FRAC-1))) >>> GAIN_FRAC;
	assign blend_sum = sum_q + prod_q;
	assign blend_ang = sat_angle(blend_sum >>> KEEP_FRAC);

	// CORDIC vectoring datapath
	assign y_src = axis_q ? ax_q : ay_q;
	assign xs    = XY_W'(az_q) <<< CORDIC_PRESCALE;
	assign ys    = XY_W'(y_src) <<< CORDIC_PRESCALE;
	assign sx    = x_q >>> cnt_q;
	assign sy    = y_q >>> cnt_q;
	assign tbl   = $signed(Z_W'(atan_entry(TBL_IDX_W'(cnt_q))));
	assign z_rnd = z_q + Z_W'(2**(SH-1));
	assign z_shr = z_rnd >>> SH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			keep_q      <= KEEP_W'(KEEP_RST);
			mag_low_q   <= MAG_W'(MAG_LOW_RST);
			mag_high_q  <= MAG_W'(MAG_HIGH_RST);
			gain_q      <= GAIN_W'(GAIN_RST);
			pitch_q     <= '0;
			roll_q      <= '0;
			axis_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_idx)
					REG_BLEND_KEEP: keep_q     <= pwdata[KEEP_W-1:0];
					REG_MAG_LOW:    mag_low_q  <= pwdata[MAG_W-1:0];
					REG_MAG_HIGH:   mag_high_q <= pwdata[MAG_W-1:0];
					REG_GYRO_GAIN:  gain_q     <= pwdata[GAIN_W-1:0];
				endcase
			end
			// S_OUT reloads the register itself
			if (result.valid && result.ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (sample.valid) begin
						state_q <= S_GX;
					end
				end
				S_GX: state_q <= S_GY;
				S_GY: begin
					pitch_q <= sat_angle(P_W'(pitch_q) + gyro_step);
					state_q <= S_GEND;
				end
				S_GEND: begin
					roll_q  <= sat_angle(P_W'(roll_q) - gyro_step);
					axis_q  <= 1'b0;
					state_q <= corr_q ? S_CINIT : S_OUT;
				end
				S_CINIT: begin
					cnt_q   <= '0;
					state_q <= S_CITER;
				end
				S_CITER: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(NSTEPS-1)) begin
						state_q <= S_CROUND;
					end
				end
				S_CROUND: state_q <= S_BA;
				S_BA:     state_q <= S_BB;
				S_BB:     state_q <= S_BC;
				S_BC: begin
					if (axis_q) begin
						roll_q  <= blend_ang;
						state_q <= S_OUT;
					end else begin
						pitch_q <= blend_ang;
						state_q <= S_CINIT;
					end
					axis_q <= 1'b1;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		if (in_acc) begin
			ax_q <= sample.accel_x;
			ay_q <= sample.accel_y;
			az_q <= sample.accel_z;
			gx_q <= sample.gyro_x;
			gy_q <= sample.gyro_y;
		end
		if (state_q == S_GX) begin
			corr_q <= corr_d;
		end
		if (state_q == S_CINIT) begin
			zero_q <= (az_q == '0) && (y_src == '0);
			// fold the left half plane by a quarter turn
			if (az_q < 0) begin
				if (y_src >= 0) begin
					x_q <= ys;
					y_q <= -xs;
					z_q <= Z_W'(QUARTER_TURN);
				end else begin
					x_q <= -ys;
					y_q <= xs;
					z_q <= -Z_W'(QUARTER_TURN);
				end
			end else begin
				x_q <= xs;
				y_q <= ys;
				z_q <= '0;
			end
		end
		if (state_q == S_CITER) begin
			if (y_q >= 0) begin
				x_q <= x_q + sy;
				y_q <= y_q - sx;
				z_q <= z_q + tbl;
			end else begin
				x_q <= x_q - sy;
				y_q <= y_q + sx;
				z_q <= z_q - tbl;
			end
		end
		if (state_q == S_CROUND) begin
			acc_q <= zero_q ? '0 : z_shr[ACC_W-1:0];
		end
		if (state_q == S_BB) begin
			sum_q <= prod_q + P_W'(2**(KEEP_FRAC-1));
		end
		if (state_q == S_OUT && out_free) begin
			out_pitch_q <= pitch_q;
			out_roll_q  <= roll_q;
			out_corr_q  <= corr_q;
		end
	end

	`CTF_ASSERT_NEXT(a_accept_starts, in_acc, state_q == S_GX, "accepted item did not start")
	`CTF_ASSERT_SAME(a_cordic_needs_corr, state_q == S_CINIT, corr_q, "CORDIC run without blend")
	`CTF_ASSERT_SAME(a_cnt_bound, state_q == S_CITER, cnt_q <= CNT_W'(NSTEPS-1), "step count overrun")
	`CTF_ASSERT_NEXT(a_result_load, state_q == S_OUT && out_free, result.valid && state_q == S_IDLE && result.pitch_angle == $past(pitch_q), "result load mismatch")

endmodule

// File: tb/sv/tb_top.sv
module tb_top import ctf_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT   = 2000;
	localparam int PHASE_SETTLE = 8;
	localparam int END_SETTLE   = 60;
	localparam int RAND_PHASES  = 6;
	localparam int PHASE_TICKS  = 165;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] ax;
		logic signed [SAMPLE_W-1:0] ay;
		logic signed [SAMPLE_W-1:0] az;
		logic signed [SAMPLE_W-1:0] gx;
		logic signed [SAMPLE_W-1:0] gy;
	} tick_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] pitch;
		logic signed [ANGLE_W-1:0] roll;
		logic                      corrected;
	} tilt_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	ctf_in_if  smp ();
	ctf_out_if res ();

	complementary_tilt_filter DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (smp),
		.result  (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #1 clk = ~clk;

	// filter state and register copies
	logic [KEEP_W-1:0] keep_reg   = KEEP_W'(KEEP_RST);
	logic [MAG_W-1:0]  mag_lo_reg = MAG_W'(MAG_LOW_RST);
	logic [MAG_W-1:0]  mag_hi_reg = MAG_W'(MAG_HIGH_RST);
	logic [GAIN_W-1:0] gain_reg   = GAIN_W'(GAIN_RST);
	longint pitch_est = 0;
	longint roll_est  = 0;

	longint atan_lut [0:TBL_LEN-1] = '{
		47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
		234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29, 14, 7
	};

	tick_t tick_q [$];
	tilt_t tilt_q [$];

	bit calm;
	int errors;
	int quiet_cycles;
	int gap_left;
	int stall_left;
	logic in_taken;
	logic out_taken;

	function automatic longint clamp_angle(longint v);
		if (v > longint'(ANGLE_MAX))
			return longint'(ANGLE_MAX);
		if (v < longint'(ANGLE_MIN))
			return longint'(ANGLE_MIN);
		return v;
	endfunction

	function automatic longint sample_mag(logic signed [SAMPLE_W-1:0] s);
		longint v;
		v = longint'(s);
		return (v < 0) ? -v : v;
	endfunction

	// atan2(y, x) in 1/4096 degree units, vectoring mode with floor shifts
	function automatic longint tilt_deg(longint y, longint x);
		longint vx, vy, z, t;
		int step;
		int shift;
		shift = TBL_FRAC - ANGLE_FRAC_BITS_DEF;
		if (x == 0 && y == 0)
			return 0;
		vx = x * 256;
		vy = y * 256;
		z = 0;
		if (vx < 0) begin
			t = vx;
			if (vy >= 0) begin
				vx = vy;
				vy = -t;
				z = longint'(QUARTER_TURN);
			end else begin
				vx = -vy;
				vy = t;
				z = -longint'(QUARTER_TURN);
			end
		end
		for (step = 0; step < CORDIC_STEPS_DEF && step < TBL_LEN; step++) begin
			t = vx;
			if (vy >= 0) begin
				vx = vx + (vy >>> step);
				vy = vy - (t >>> step);
				z = z + atan_lut[step];
			end else begin
				vx = vx - (vy >>> step);
				vy = vy + (t >>> step);
				z = z - atan_lut[step];
			end
		end
		return (z + (longint'(1) << (shift - 1))) >>> shift;
	endfunction

	function automatic longint mix_angle(longint a, longint acc, longint keep);
		longint s;
		s = keep * a + (longint'(KEEP_ONE) - keep) * acc + 32768;
		return clamp_angle(s >>> KEEP_FRAC);
	endfunction

	function automatic tilt_t advance_tilt(tick_t t);
		longint gain, keep, mag;
		bit blend_on;
		tilt_t r;
		gain = longint'(gain_reg);
		keep = (keep_reg > KEEP_ONE) ? longint'(KEEP_ONE) : longint'(keep_reg);
		pitch_est = clamp_angle(pitch_est + ((longint'(t.gx) * gain + 128) >>> GAIN_FRAC));
		roll_est = clamp_angle(roll_est - ((longint'(t.gy) * gain + 128) >>> GAIN_FRAC));
		mag = sample_mag(t.ax) + sample_mag(t.ay) + sample_mag(t.az);
		blend_on = mag > longint'(mag_lo_reg) && mag < longint'(mag_hi_reg);
		if (blend_on) begin
			pitch_est = mix_angle(pitch_est, tilt_deg(longint'(t.ay), longint'(t.az)), keep);
			roll_est = mix_angle(roll_est, tilt_deg(longint'(t.ax), longint'(t.az)), keep);
		end
		r.pitch = pitch_est[ANGLE_W-1:0];
		r.roll = roll_est[ANGLE_W-1:0];
		r.corrected = blend_on;
		return r;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample(int unsigned span);
		return SAMPLE_W'(int'($urandom_range(0, 2 * span - 1)) - int'(span));
	endfunction

	task automatic add_tick(int ax, int ay, int az, int gx, int gy);
		tick_q.push_back({SAMPLE_W'(ax), SAMPLE_W'(ay), SAMPLE_W'(az),
			SAMPLE_W'(gx), SAMPLE_W'(gy)});
	endtask

	// hold until every queued item is taken and every result is back
	task automatic settle(int extra);
		while (tick_q.size() != 0 || smp.valid || tilt_q.size() != 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	// write one register with junk above its width, then read it back
	task automatic program_reg(reg_idx_t idx, int unsigned value);
		logic [CFG_DATA_W-1:0] mask;
		logic [CFG_DATA_W-1:0] word;
		mask = (idx == REG_GYRO_GAIN) ? 32'h0000_FFFF : 32'h0001_FFFF;
		word = value | ($urandom() & ~mask);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== (word & mask)) begin
			$display("%0t register %s readback: expected %0h, got %0h",
				$time, idx.name(), word & mask, prdata);
			errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		unique case (idx)
			REG_BLEND_KEEP: keep_reg = word[KEEP_W-1:0];
			REG_MAG_LOW:    mag_lo_reg = word[MAG_W-1:0];
			REG_MAG_HIGH:   mag_hi_reg = word[MAG_W-1:0];
			REG_GYRO_GAIN:  gain_reg = word[GAIN_W-1:0];
		endcase
		@(negedge clk);
	endtask

	// sample side: present queued items with a random gap after each one taken
	always @(negedge clk or negedge arst_n) begin : feed
		int wait_n;
		tick_t nxt;
		if (!arst_n) begin
			smp.valid <= 1'b0;
			smp.accel_x <= '0;
			smp.accel_y <= '0;
			smp.accel_z <= '0;
			smp.gyro_x <= '0;
			smp.gyro_y <= '0;
			gap_left <= 0;
		end else if (!smp.valid || in_taken) begin
			wait_n = gap_left;
			if (in_taken)
				wait_n = calm ? 0 : $urandom_range(0, 6);
			if (wait_n == 0 && tick_q.size() != 0) begin
				nxt = tick_q.pop_front();
				smp.accel_x <= nxt.ax;
				smp.accel_y <= nxt.ay;
				smp.accel_z <= nxt.az;
				smp.gyro_x <= nxt.gx;
				smp.gyro_y <= nxt.gy;
				smp.valid <= 1'b1;
				gap_left <= 0;
			end else begin
				smp.valid <= 1'b0;
				gap_left <= (wait_n == 0) ? 0 : wait_n - 1;
			end
		end
	end

	// result side: drop ready for a random number of cycles after each item
	always @(negedge clk or negedge arst_n) begin : drain
		int hold_n;
		if (!arst_n) begin
			res.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			hold_n = stall_left;
			if (out_taken)
				hold_n = calm ? 0 : $urandom_range(0, 6);
			res.ready <= (hold_n == 0);
			stall_left <= (hold_n == 0) ? 0 : hold_n - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch
		tilt_t want;
		if (!arst_n) begin
			in_taken <= 1'b0;
			out_taken <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			in_taken <= smp.valid && smp.ready;
			out_taken <= res.valid && res.ready;
			if (smp.valid && smp.ready)
				tilt_q.push_back(advance_tilt(tick_t'({smp.accel_x, smp.accel_y,
					smp.accel_z, smp.gyro_x, smp.gyro_y})));
			if (res.valid && res.ready) begin
				if (tilt_q.size() == 0) begin
					$display("%0t unexpected item: pitch %0d roll %0d corrected %0b",
						$time, res.pitch_angle, res.roll_angle, res.corrected);
					errors++;
				end else begin
					want = tilt_q.pop_front();
					if (res.pitch_angle !== want.pitch) begin
						$display("%0t pitch_angle: expected %0d, got %0d",
							$time, want.pitch, res.pitch_angle);
						errors++;
					end
					if (res.roll_angle !== want.roll) begin
						$display("%0t roll_angle: expected %0d, got %0d",
							$time, want.roll, res.roll_angle);
						errors++;
					end
					if (res.corrected !== want.corrected) begin
						$display("%0t corrected: expected %0b, got %0b",
							$time, want.corrected, res.corrected);
						errors++;
					end
				end
			end
			if ((smp.valid && smp.ready) || (res.valid && res.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("%0t no item moved for %0d cycles", $time, IDLE_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		int ph, k;
		int unsigned a_span, g_span, lo;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		arst_n <= 1'b0;
		calm = 1'b0;
		errors = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: boundaries of the magnitude window and each quadrant
		add_tick(0, 0, 0, 0, 0);
		add_tick(16000, 0, 0, 0, 0);             // pitch sees the zero vector
		add_tick(0, 0, 0, 32767, -32768);
		add_tick(0, 5000, 10000, -32768, 32767);
		add_tick(0, 5000, -10000, 100, -100);
		add_tick(0, -5000, -10000, 0, 0);
		add_tick(-5000, 0, -10000, -1, 1);
		add_tick(0, 0, -16384, 0, 0);
		add_tick(-32768, -32768, -32768, -32768, -32768);
		add_tick(32767, 32767, 32767, 32767, 32767);
		add_tick(8192, 0, 0, 0, 0);
		add_tick(8193, 0, 0, 0, 0);
		add_tick(16384, 16384, 0, 0, 0);
		add_tick(16384, 16383, 0, 0, 0);
		settle(PHASE_SETTLE);

		// full gain drives both angles into saturation; keep above one acts as one
		program_reg(REG_BLEND_KEEP, 131071);
		program_reg(REG_MAG_LOW, 0);
		program_reg(REG_MAG_HIGH, 98304);
		program_reg(REG_GYRO_GAIN, 65535);
		add_tick(100, 200, 300, 32767, -32768);
		add_tick(100, 200, 300, 32767, -32768);
		add_tick(100, 200, 300, -32768, 32767);
		add_tick(100, 200, 300, -32768, 32767);
		add_tick(100, 200, 300, -32768, 32767);
		settle(PHASE_SETTLE);

		for (ph = 0; ph < RAND_PHASES; ph++) begin
			unique case (ph)
				0: begin
					program_reg(REG_BLEND_KEEP, KEEP_RST);
					program_reg(REG_MAG_LOW, MAG_LOW_RST);
					program_reg(REG_MAG_HIGH, MAG_HIGH_RST);
					program_reg(REG_GYRO_GAIN, GAIN_RST);
				end
				1: begin
					program_reg(REG_BLEND_KEEP, 0);
					program_reg(REG_MAG_LOW, 0);
					program_reg(REG_MAG_HIGH, 98304);
					program_reg(REG_GYRO_GAIN, 65535);
				end
				2: begin
					program_reg(REG_BLEND_KEEP, KEEP_ONE);
					program_reg(REG_MAG_HIGH, 131071);
					program_reg(REG_GYRO_GAIN, 1);
				end
				3: begin
					lo = $urandom_range(0, 20000);
					program_reg(REG_BLEND_KEEP, $urandom_range(0, KEEP_ONE));
					program_reg(REG_MAG_LOW, lo);
					program_reg(REG_MAG_HIGH, $urandom_range(lo, 98304));
					program_reg(REG_GYRO_GAIN, $urandom_range(0, 65535));
				end
				4: begin
					// empty window: no blend at all
					program_reg(REG_BLEND_KEEP, $urandom_range(0, 131071));
					program_reg(REG_MAG_LOW, 50000);
					program_reg(REG_MAG_HIGH, 1000);
					program_reg(REG_GYRO_GAIN, $urandom_range(0, 65535));
				end
				default: begin
					program_reg(REG_BLEND_KEEP, $urandom_range(60000, KEEP_ONE));
					program_reg(REG_MAG_LOW, 4000);
					program_reg(REG_MAG_HIGH, 40000);
					program_reg(REG_GYRO_GAIN, 0);
				end
			endcase
			calm = (ph == 1 || ph == 4);
			// vary the scale per item so the sum lands on both sides of the window
			for (k = 0; k < PHASE_TICKS; k++) begin
				a_span = 1 << $urandom_range(6, 15);
				g_span = 1 << $urandom_range(4, 15);
				tick_q.push_back({rand_sample(a_span), rand_sample(a_span),
					rand_sample(a_span), rand_sample(g_span), rand_sample(g_span)});
			end
			settle(PHASE_SETTLE);
		end

		settle(END_SETTLE);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hdl
hdl/ctf_pkg.sv
hdl/ctf_if.sv
hdl/complementary_tilt_filter.sv
tb/sv/tb_top.sv
